@@ sv/svt_pkg.sv @@
// ----------------------------------------------------------------------------
// svt_pkg
// Shared types, constants and the saturating adder for the summed volume table.
// ----------------------------------------------------------------------------
package svt_pkg;

	localparam int SMP_W = 16;
	localparam int SUM_W = 48;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_PLANES = 2'd0,
		REG_ROWS   = 2'd1,
		REG_COLS   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] planes;
		logic [12:0] rows;
		logic [8:0]  cols;
	} cfg_t;

	// per-word flags from the front
	typedef struct packed {
		logic first;     // col == 0
		logic row_nz;    // row > 0
		logic plane_nz;  // plane > 0
		logic last;      // final word of the array
	} flags_t;

	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0] a,
		input logic signed [SUM_W-1:0] b
	);
		logic signed [SUM_W:0] s;
		s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
		if (s[SUM_W] != s[SUM_W-1]) begin
			return s[SUM_W] ? SUM_MIN : SUM_MAX;
		end
		return s[SUM_W-1:0];
	endfunction

	function automatic logic signed [SUM_W-1:0] sext_smp(input logic signed [SMP_W-1:0] x);
		return {{(SUM_W-SMP_W){x[SMP_W-1]}}, x};
	endfunction

endpackage

@@ sv/svt_ram.sv @@
// ----------------------------------------------------------------------------
// svt_ram
// Simple dual-port RAM, one write and one registered read port, read-old-data.
// ----------------------------------------------------------------------------
module svt_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/svt_front.sv @@
// ----------------------------------------------------------------------------
// svt_front
// Position tracking: tags each accepted sample with column, store index, flags.
// ----------------------------------------------------------------------------
module svt_front #(
	parameter int PLANE_MAX = 4096,
	parameter int LINE_MAX  = 256,
	localparam int CW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1,
	localparam int AW = (PLANE_MAX > 1) ? $clog2(PLANE_MAX) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  svt_pkg::cfg_t              cfg,
	input  logic                       restart,
	input  logic                       in_valid,
	input  logic signed [svt_pkg::SMP_W-1:0] sample,
	output logic                       in_stall,
	input  logic                       q_full,
	output logic                       push,
	output logic signed [svt_pkg::SMP_W-1:0] push_sample,
	output logic [CW-1:0]              push_col,
	output logic [AW-1:0]              push_idx,
	output svt_pkg::flags_t            push_flags
);
	localparam int EW = $clog2(PLANE_MAX + 2 * LINE_MAX + 65536 + 1) + 1;
	localparam int RW = AW;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [15:0]   plane_q;
	logic [EW-1:0] rb_q;     // row * cols

	logic [EW-1:0] nc, nr, np;
	logic          col_wrap, row_wrap, plane_wrap;

	always_comb begin
		if (cfg.cols == '0) begin
			nc = EW'(1);
		end else if (EW'(cfg.cols) > EW'(LINE_MAX)) begin
			nc = EW'(LINE_MAX);
		end else begin
			nc = EW'(cfg.cols);
		end
		nr = (cfg.rows == '0) ? EW'(1) : EW'(cfg.rows);
		np = (cfg.planes == '0) ? EW'(1) : EW'(cfg.planes);
		col_wrap   = (EW'(col_q) + EW'(1)) >= nc;
		// second test caps rows at PLANE_MAX / cols
		row_wrap   = ((EW'(row_q) + EW'(1)) >= nr) ||
		             ((rb_q + (nc << 1)) > EW'(PLANE_MAX));
		plane_wrap = (EW'(plane_q) + EW'(1)) >= np;
	end

	assign in_stall    = q_full;
	assign push        = in_valid && !q_full;
	assign push_sample = sample;
	assign push_col    = col_q;
	assign push_idx    = AW'(rb_q + EW'(col_q));

	always_comb begin
		push_flags.first    = (col_q == '0);
		push_flags.row_nz   = (row_q != '0);
		push_flags.plane_nz = (plane_q != '0);
		push_flags.last     = col_wrap && row_wrap && plane_wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			plane_q <= '0;
			rb_q    <= '0;
		end else if (restart) begin
			col_q   <= '0;
			row_q   <= '0;
			plane_q <= '0;
			rb_q    <= '0;
		end else if (push) begin
			if (!col_wrap) begin
				col_q <= CW'(col_q + 1'b1);
			end else begin
				col_q <= '0;
				if (!row_wrap) begin
					row_q <= RW'(row_q + 1'b1);
					rb_q  <= rb_q + nc;
				end else begin
					row_q <= '0;
					rb_q  <= '0;
					plane_q <= plane_wrap ? '0 : plane_q + 16'd1;
				end
			end
		end
	end

endmodule

@@ sv/svt_queue.sv @@
// ----------------------------------------------------------------------------
// svt_queue
// Small circular FIFO between front and back.
// ----------------------------------------------------------------------------
module svt_queue #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [NW-1:0]    cnt_q;

	assign full  = (cnt_q == NW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wptr_q + 1'b1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= NW'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= NW'(cnt_q - 1'b1);
			end
		end
	end

endmodule

@@ sv/svt_back.sv @@
// ----------------------------------------------------------------------------
// svt_back
// Sum pipeline: row sum, in-plane partial, full sum, output register.
// ----------------------------------------------------------------------------
module svt_back #(
	parameter int PLANE_MAX = 4096,
	parameter int LINE_MAX  = 256,
	localparam int CW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1,
	localparam int AW = (PLANE_MAX > 1) ? $clog2(PLANE_MAX) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	output logic                              pop,
	input  logic signed [svt_pkg::SMP_W-1:0]  head_sample,
	input  logic [CW-1:0]                     head_col,
	input  logic [AW-1:0]                     head_idx,
	input  svt_pkg::flags_t                   head_flags,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [svt_pkg::SUM_W-1:0]  sum,
	output logic                              last
);
	localparam int SW = svt_pkg::SUM_W;

	logic en;

	// s1: row running sum
	logic                          v_s1;
	logic signed [svt_pkg::SMP_W-1:0] x_s1;
	logic [CW-1:0]                 col_s1;
	logic [AW-1:0]                 idx_s1;
	svt_pkg::flags_t               fl_s1;
	logic signed [SW-1:0]          rr_q, rr_new;

	// s2: in-plane partial
	logic                 v_s2;
	logic signed [SW-1:0] rr_s2;
	logic [CW-1:0]        col_s2;
	logic [AW-1:0]        idx_s2;
	svt_pkg::flags_t      fl_s2;
	logic signed [SW-1:0] rp_rd, rp_fwd, part;

	// s3: full sum
	logic                 v_s3;
	logic signed [SW-1:0] part_s3;
	logic [CW-1:0]        col_s3;
	logic [AW-1:0]        idx_s3;
	svt_pkg::flags_t      fl_s3;
	logic signed [SW-1:0] ps_rd, ps_fwd, full;

	// s4: output register
	logic                 v_s4;
	logic signed [SW-1:0] sum_s4;
	logic                 last_s4;
	logic [AW-1:0]        idx_s4;

	assign en  = !v_s4 || !out_stall;
	assign pop = en && !q_empty;

	assign rr_new = fl_s1.first ? svt_pkg::sext_smp(x_s1)
	                            : svt_pkg::sat_add(rr_q, svt_pkg::sext_smp(x_s1));

	// previous word wrote the same entry on the edge this one read it
	assign rp_fwd = (v_s3 && col_s3 == col_s2) ? part_s3 : rp_rd;
	assign part   = fl_s2.row_nz ? svt_pkg::sat_add(rr_s2, rp_fwd) : rr_s2;

	assign ps_fwd = (v_s4 && idx_s4 == idx_s3) ? sum_s4 : ps_rd;
	assign full   = fl_s3.plane_nz ? svt_pkg::sat_add(part_s3, ps_fwd) : part_s3;

	svt_ram #(.WIDTH(SW), .DEPTH(LINE_MAX)) u_row_ram (
		.clk   (clk),
		.we    (en && v_s2),
		.waddr (col_s2),
		.wdata (part),
		.re    (en),
		.raddr (col_s1),
		.rdata (rp_rd)
	);

	svt_ram #(.WIDTH(SW), .DEPTH(PLANE_MAX)) u_plane_ram (
		.clk   (clk),
		.we    (en && v_s3),
		.waddr (idx_s3),
		.wdata (full),
		.re    (en),
		.raddr (idx_s2),
		.rdata (ps_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= head_sample;
			col_s1  <= head_col;
			idx_s1  <= head_idx;
			fl_s1   <= head_flags;
			if (v_s1) begin
				rr_q <= rr_new;
			end
			rr_s2   <= rr_new;
			col_s2  <= col_s1;
			idx_s2  <= idx_s1;
			fl_s2   <= fl_s1;
			part_s3 <= part;
			col_s3  <= col_s2;
			idx_s3  <= idx_s2;
			fl_s3   <= fl_s2;
			sum_s4  <= full;
			last_s4 <= fl_s3.last;
			idx_s4  <= idx_s3;
		end
	end

	assign out_valid = v_s4;
	assign sum       = sum_s4;
	assign last      = last_s4;

endmodule

@@ sv/summed_volume_table_core.sv @@
// ----------------------------------------------------------------------------
// summed_volume_table_core
// Streaming inclusive prefix sum over 1-D, 2-D and 3-D arrays in raster order.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------
//  in       | in_valid / in_stall       | sample  (s16, Q8.8)
//  out      | out_valid / out_stall     | sum (s48, Q40.8, saturated), last
//  config   | APB, pready tied high     | planes @0x0, rows @0x4, cols @0x8
//
//  One word per cycle sustained while out_stall is low; an accepted word is
//  written into the queue, then passes the row-sum stage, partial stage,
//  full-sum stage and output register before out_valid rises.
//  The rate is held by the single-cycle row-sum register loop and the
//  one-read/one-write RAMs with a one-word forward on each.
//  Reset clears control state only; stores are not cleared and hold
//  garbage until written within an array.
//  out_stall with a result held freezes the whole back pipeline; the 4-word
//  queue lets the front keep taking words until it fills, then in_stall rises.
// ----------------------------------------------------------------------------
module summed_volume_table_core #(
	parameter int PLANE_MAX = 4096,
	parameter int LINE_MAX  = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// config port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [3:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	// input stream
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [svt_pkg::SMP_W-1:0]  sample,
	// output stream
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [svt_pkg::SUM_W-1:0]  sum,
	output logic                              last
);
	localparam int CW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
	localparam int AW = (PLANE_MAX > 1) ? $clog2(PLANE_MAX) : 1;
	localparam int FW = $bits(svt_pkg::flags_t);
	localparam int QW = svt_pkg::SMP_W + CW + AW + FW;
	localparam int QDEPTH = 4;

	// config registers
	svt_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic          restart;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_comb begin
		restart = 1'b0;
		unique case (svt_pkg::reg_idx_t'(paddr[3:2]))
			svt_pkg::REG_PLANES: restart = wr_en;
			svt_pkg::REG_ROWS:   restart = wr_en;
			svt_pkg::REG_COLS:   restart = wr_en;
			default:             restart = 1'b0;   // beyond the map: ignored
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.planes <= 16'd1;
			cfg_q.rows   <= 13'd1;
			cfg_q.cols   <= 9'd1;
		end else if (wr_en) begin
			unique case (svt_pkg::reg_idx_t'(paddr[3:2]))
				svt_pkg::REG_PLANES: cfg_q.planes <= pwdata[15:0];
				svt_pkg::REG_ROWS:   cfg_q.rows   <= pwdata[12:0];
				svt_pkg::REG_COLS:   cfg_q.cols   <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (svt_pkg::reg_idx_t'(paddr[3:2]))
			svt_pkg::REG_PLANES: prdata = {16'd0, cfg_q.planes};
			svt_pkg::REG_ROWS:   prdata = {19'd0, cfg_q.rows};
			svt_pkg::REG_COLS:   prdata = {23'd0, cfg_q.cols};
			default:             prdata = 32'd0;
		endcase
	end

	// front -> queue
	logic                             q_push, q_pop, q_full, q_empty;
	logic signed [svt_pkg::SMP_W-1:0] push_sample;
	logic [CW-1:0]                    push_col;
	logic [AW-1:0]                    push_idx;
	svt_pkg::flags_t                  push_flags;
	logic [QW-1:0]                    q_wdata, q_rdata;

	svt_front #(.PLANE_MAX(PLANE_MAX), .LINE_MAX(LINE_MAX)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.restart     (restart),
		.in_valid    (in_valid),
		.sample      (sample),
		.in_stall    (in_stall),
		.q_full      (q_full),
		.push        (q_push),
		.push_sample (push_sample),
		.push_col    (push_col),
		.push_idx    (push_idx),
		.push_flags  (push_flags)
	);

	assign q_wdata = {push_sample, push_col, push_idx, push_flags};

	svt_queue #(.WIDTH(QW), .DEPTH(QDEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	// queue head unpacked for the back
	logic signed [svt_pkg::SMP_W-1:0] head_sample;
	logic [CW-1:0]                    head_col;
	logic [AW-1:0]                    head_idx;
	svt_pkg::flags_t                  head_flags;

	assign {head_sample, head_col, head_idx, head_flags} = q_rdata;

	svt_back #(.PLANE_MAX(PLANE_MAX), .LINE_MAX(LINE_MAX)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.pop         (q_pop),
		.head_sample (head_sample),
		.head_col    (head_col),
		.head_idx    (head_idx),
		.head_flags  (head_flags),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sum         (sum),
		.last        (last)
	);

	// a word that is not first in its row must sit past column zero
	a_first_col: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !push_flags.first) |-> (push_col != '0))
		else $error("non-first word at column zero");

	// in the first row the store index is the column itself
	a_row0_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !push_flags.row_nz) |-> (push_idx == AW'(push_col)))
		else $error("row base nonzero in first row");

	// queue count is consistent: full and empty never together
	a_q_count: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_empty)
		else $error("queue full and empty at once");

endmodule

@@ verif/tb_summed_volume_table_core.sv @@
// ----------------------------------------------------------------------------
// tb_summed_volume_table_core
// Self-checking bench for the streaming summed volume table.
// Words go in through a randomly gapped sender. Results come out through a
// randomly stalling sink. Each accepted result is checked against a local
// cumulative-sum predictor that keeps its own row, line and plane stores.
// Lengths are set over APB and read back while the pipe is empty.
// ----------------------------------------------------------------------------
module tb_summed_volume_table_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SMP_W         = svt_pkg::SMP_W;
	localparam int SUM_W         = svt_pkg::SUM_W;
	localparam int PLANE_MAX     = 4096;
	localparam int LINE_MAX      = 256;
	localparam int GAP_MAX       = 12;       // longest per-word gap or stall
	localparam int PIPE_LAT      = 4;        // accept to out_valid
	localparam int SETTLE_CYCLES = 4 * PIPE_LAT;
	localparam int HOLD_CYCLES   = 200;      // long sink hold-off, fills the queue
	localparam int RANDOM_WORDS  = 400;

	// paddr[3:2] value that maps to no register
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef struct {
		logic signed [SUM_W-1:0] total;
		logic                    is_last;
	} vol_result_t;

	// DUT signals, all inputs known from time zero
	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    psel      = 1'b0;
	logic                    penable   = 1'b0;
	logic                    pwrite    = 1'b0;
	logic [3:0]              paddr     = '0;
	logic [31:0]             pwdata    = '0;
	logic [31:0]             prdata;
	logic                    pready;
	logic                    in_valid  = 1'b0;
	logic                    in_stall;
	logic signed [SMP_W-1:0] sample    = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [SUM_W-1:0] sum;
	logic                    last;

	// predictor state: mirrors the block after reset
	longint      plane_acc [PLANE_MAX];
	longint      line_acc  [LINE_MAX];
	longint      run_acc   = 0;
	int          at_plane  = 0;
	int          at_row    = 0;
	int          at_col    = 0;
	logic [15:0] cfg_planes = 16'd1;
	logic [12:0] cfg_rows   = 13'd1;
	logic [8:0]  cfg_cols   = 9'd1;

	vol_result_t expected_sums[$];
	int          errors     = 0;
	int          words_sent = 0;
	bit          gaps_on    = 1'b1;   // shared by sender and sink
	int          hold_req   = 0;      // sink picks this up as a one-off long stall

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	summed_volume_table_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sum       (sum),
		.last      (last)
	);

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	function automatic longint clamp48(input longint v);
		if (v > longint'(svt_pkg::SUM_MAX)) return longint'(svt_pkg::SUM_MAX);
		if (v < longint'(svt_pkg::SUM_MIN)) return longint'(svt_pkg::SUM_MIN);
		return v;
	endfunction

	// Lengths as the block uses them: zero acts as one, cols capped at the
	// line store, rows capped so rows*cols fits the plane store.
	function automatic void eff_lengths(output int np, output int nr, output int nc);
		np = (cfg_planes == '0) ? 1 : int'(cfg_planes);
		nc = (cfg_cols == '0) ? 1 : int'(cfg_cols);
		if (nc > LINE_MAX) nc = LINE_MAX;
		nr = (cfg_rows == '0) ? 1 : int'(cfg_rows);
		if (nr > PLANE_MAX / nc) nr = PLANE_MAX / nc;
	endfunction

	function automatic vol_result_t volume_predict(input logic signed [SMP_W-1:0] x);
		int          np, nr, nc, idx;
		longint      part, full;
		vol_result_t r;
		eff_lengths(np, nr, nc);
		if (at_col >= nc) at_col = 0;
		if (at_row >= nr) at_row = 0;
		if (at_plane >= np) at_plane = 0;

		// row sum, then add the line above, then the plane behind
		if (at_col == 0) run_acc = clamp48(longint'(x));
		else run_acc = clamp48(run_acc + longint'(x));
		part = run_acc;
		if (at_row > 0) part = clamp48(part + line_acc[at_col]);
		line_acc[at_col] = part;
		idx  = at_row * nc + at_col;
		full = part;
		if (at_plane > 0) full = clamp48(full + plane_acc[idx]);
		plane_acc[idx] = full;

		r.total   = full[SUM_W-1:0];
		r.is_last = (at_col + 1 >= nc) && (at_row + 1 >= nr) && (at_plane + 1 >= np);

		if (at_col + 1 < nc) begin
			at_col++;
		end else begin
			at_col = 0;
			if (at_row + 1 < nr) begin
				at_row++;
			end else begin
				at_row = 0;
				at_plane = (at_plane + 1 < np) ? at_plane + 1 : 0;
			end
		end
		if (r.is_last) run_acc = 0;
		return r;
	endfunction

	// A write to a real register restarts the array; the spare slot does nothing.
	function automatic void cfg_apply(input logic [1:0] idx, input logic [31:0] v);
		if (idx == svt_pkg::REG_PLANES) cfg_planes = v[15:0];
		else if (idx == svt_pkg::REG_ROWS) cfg_rows = v[12:0];
		else if (idx == svt_pkg::REG_COLS) cfg_cols = v[8:0];
		else return;
		run_acc  = 0;
		at_plane = 0;
		at_row   = 0;
		at_col   = 0;
	endfunction

	function automatic logic [31:0] cfg_value(input logic [1:0] idx);
		if (idx == svt_pkg::REG_PLANES) return {16'd0, cfg_planes};
		if (idx == svt_pkg::REG_ROWS) return {19'd0, cfg_rows};
		return {23'd0, cfg_cols};
	endfunction

	// ------------------------------------------------------------------------
	// Bus and stream drivers
	// ------------------------------------------------------------------------

	// Setup cycle, access cycle, then an idle cycle so back-to-back
	// transfers never assign psel twice in one step.
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		cfg_apply(idx, v);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read(input logic [1:0] idx);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== cfg_value(idx)) begin
			$error("prdata mismatch at index %0d: expected %0h, actual %0h",
				idx, cfg_value(idx), prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one word after a random gap; the expectation is built the moment
	// the word is taken. With no gap valid simply stays high.
	task automatic send_word(input logic signed [SMP_W-1:0] x);
		int gap;
		gap = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= x;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_sums.push_back(volume_predict(x));
		words_sent++;
	endtask

	// Stop offering, wait for every expected sum, then let the pipe go quiet.
	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (expected_sums.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_shape(input logic [31:0] p, input logic [31:0] r, input logic [31:0] c);
		drain_pipe();
		reg_write(svt_pkg::REG_PLANES, p);
		reg_write(svt_pkg::REG_ROWS, r);
		reg_write(svt_pkg::REG_COLS, c);
		reg_read(svt_pkg::REG_PLANES);
		reg_read(svt_pkg::REG_ROWS);
		reg_read(svt_pkg::REG_COLS);
	endtask

	function automatic logic signed [SMP_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return SMP_W'($urandom_range(0, 16)) - 16'sd8;
			default: return SMP_W'($urandom());
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Result sink and checker
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int          wait_n;
		vol_result_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// one-off long hold when a test asks for it, else a random stall
			if (hold_req > 0) begin
				wait_n   = hold_req;
				hold_req = 0;
			end else begin
				wait_n = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
			end
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (expected_sums.size() == 0) begin
				$error("unexpected result word: sum %0d last %0b", sum, last);
				errors++;
			end else begin
				want = expected_sums.pop_front();
				if (sum !== want.total) begin
					$error("sum mismatch: expected %0d, actual %0d", want.total, sum);
					errors++;
				end
				if (last !== want.is_last) begin
					$error("last mismatch: expected %0b, actual %0b", want.is_last, last);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset lengths are 1x1x1: each word is its own sum and always the last.
	task automatic test_reset_state();
		reg_read(svt_pkg::REG_PLANES);
		reg_read(svt_pkg::REG_ROWS);
		reg_read(svt_pkg::REG_COLS);
		send_word(16'sh7FFF);
		send_word(16'sh8000);
		send_word(16'sh0000);
		send_word(-16'sd1);
		send_word(16'sh0001);
		send_word(16'sh5555);
		send_word(16'shAAAA);
	endtask

	// Zero lengths, a full 2x2x2 volume at the sample extremes, oversized
	// cols and rows with the largest planes, and the tallest single column.
	task automatic test_length_extremes();
		set_shape(32'd0, 32'd0, 32'd0);
		send_word(16'sh1234);
		send_word(16'shFEDC);

		set_shape(32'd2, 32'd2, 32'd2);
		repeat (4) send_word(16'sh7FFF);
		repeat (4) send_word(16'sh8000);

		// cols 511 acts as 256, rows then capped at 16
		set_shape(32'h0000_FFFF, 32'h0000_1FFF, 32'h0000_01FF);
		repeat (3) send_word(rand_sample());

		set_shape(32'd1, 32'd4096, 32'd1);
		repeat (2) send_word(rand_sample());
	endtask

	// A write past the register list must not restart the array.
	task automatic test_spare_index();
		set_shape(32'd2, 32'd1, 32'd1);
		send_word(16'sh0100);
		drain_pipe();
		reg_write(REG_SPARE, 32'hFFFF_FFFF);
		send_word(16'sh0200);
	endtask

	// Rewriting a register mid-array starts the array over.
	task automatic test_restart_mid_array();
		set_shape(32'd1, 32'd3, 32'd1);
		send_word(16'sh0010);
		send_word(16'sh0020);
		drain_pipe();
		reg_write(svt_pkg::REG_ROWS, 32'd3);
		repeat (3) send_word(rand_sample());
	endtask

	// Sink holds off for a long stretch while the sender keeps going at full
	// rate, so the queue fills and in_stall has to rise.
	task automatic test_back_pressure();
		set_shape(32'd3, 32'd4, 32'd3);
		gaps_on  = 1'b0;
		hold_req = HOLD_CYCLES;
		repeat (36) send_word(rand_sample());
		drain_pipe();
		gaps_on = 1'b1;
	endtask

	// Mostly whole arrays of small random shapes, back to back, with some
	// truncated arrays and wild register values mixed in.
	task automatic test_random_arrays();
		int start, kind, np, nr, nc, n, total;
		logic [31:0] p, r, c;
		start = words_sent;
		while (words_sent - start < RANDOM_WORDS) begin
			kind = $urandom_range(0, 9);
			case (kind)
				6: begin p = $urandom_range(1, 40); r = 1; c = 1; end        // 1-D
				7: begin p = $urandom_range(1, 6); r = $urandom_range(1, 12); c = 1; end
				8: begin p = $urandom_range(1, 2); r = $urandom_range(1, 2);
					c = $urandom_range(100, 256); end
				9: begin p = $urandom(); r = $urandom(); c = $urandom(); end // upper bits too
				default: begin p = $urandom_range(1, 4); r = $urandom_range(1, 5);
					c = $urandom_range(1, 5); end
			endcase
			set_shape(p, r, c);
			gaps_on = ($urandom_range(0, 3) != 0);
			eff_lengths(np, nr, nc);
			n = np * nr * nc;
			if (n > 60) begin
				total = $urandom_range(1, 40);         // partial array, then restart
			end else begin
				total = n * $urandom_range(1, 3);
				if ($urandom_range(0, 4) == 0) total -= $urandom_range(0, n - 1);
			end
			repeat (total) send_word(rand_sample());
		end
		drain_pipe();
		gaps_on = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin : run_tests
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_length_extremes();
		test_spare_index();
		test_restart_mid_array();
		test_back_pressure();
		test_random_arrays();
		drain_pipe();

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Hard stop, far beyond the slowest correct run.
	initial begin : watchdog
		#(10_000_000);
		$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ sim.f @@
sv/svt_pkg.sv
sv/svt_ram.sv
sv/svt_front.sv
sv/svt_queue.sv
sv/svt_back.sv
sv/summed_volume_table_core.sv
verif/tb_summed_volume_table_core.sv
